@@ hw/rtl/optimizer_weight_update_unit_macros.svh @@
// Assertion macros used by the top-level file to check its own logic.
`ifndef OPTIMIZER_WEIGHT_UPDATE_UNIT_MACROS_SVH
`define OPTIMIZER_WEIGHT_UPDATE_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define OWU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define OWU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/owu_pkg.sv @@
`timescale 1ns / 1ps

package owu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int RATE_BITS = 31;
    localparam int MF_BITS   = 17;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam int MIDQ_DEPTH    = 4;
    localparam int MIDQ_PTR_BITS = $clog2(MIDQ_DEPTH);
    localparam int MIDQ_CNT_BITS = $clog2(MIDQ_DEPTH + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE_FX   = {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        MODE_SGD      = 2'd0,
        MODE_NESTEROV = 2'd1,
        MODE_ADAGRAD  = 2'd2,
        MODE_RMSPROP  = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEARN_RATE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOMENTUM   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RHO        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELTA      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAD_FLOOR = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAD_CEIL  = 3'd7;

    typedef struct packed {
        mode_t                mode;
        logic [RATE_BITS-1:0] learn_rate;
        logic [RATE_BITS-1:0] decay_weight;
        logic [MF_BITS-1:0]   momentum_factor;
        logic [MF_BITS-1:0]   rho_factor;
        logic [RATE_BITS-1:0] delta_term;
        word_t                grad_floor;
        word_t                grad_ceil;
    } cfg_t;

    typedef struct packed {
        word_t weight_in;
        word_t gradient_in;
        word_t history_in;
        word_t scale_in;
    } in_item_t;

    typedef struct packed {
        word_t weight_out;
        word_t history_out;
    } out_item_t;

    // Item after gradient preprocessing, tagged with the update rule it takes.
    typedef struct packed {
        mode_t mode;
        word_t w;
        word_t g;
        word_t h;
    } mid_item_t;

    typedef struct packed {
        logic [MIDQ_CNT_BITS-1:0] count;
    } midq_status_t;

    typedef struct packed {
        logic adv;
        logic oq_full;
    } bk_status_t;

    function automatic word_t add_sat(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sub_sat(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    // Round half up, drop the fraction toward minus infinity, saturate.
    function automatic word_t fx_round(input prod_t p);
        logic signed [PROD_BITS:0]           t;
        logic signed [PROD_BITS-FRAC_BITS:0] s;
        logic [PROD_BITS-FRAC_BITS-WORD_BITS+1:0] hi;
        t  = {p[PROD_BITS-1], p}
           + {{(PROD_BITS+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
        s  = t[PROD_BITS:FRAC_BITS];
        hi = s[PROD_BITS-FRAC_BITS:WORD_BITS-1];
        if ((&hi) || !(|hi))
            return s[WORD_BITS-1:0];
        return s[PROD_BITS-FRAC_BITS] ? WORD_MIN : WORD_MAX;
    endfunction

endpackage

@@ hw/rtl/owu_front.sv @@
`timescale 1ns / 1ps

module owu_front
    import owu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      accept,
    input  in_item_t  item,
    input  logic      adv,
    output logic      out_valid,
    output mid_item_t out_item
);

    typedef struct packed {
        word_t w;
        word_t g;
        word_t h;
        word_t sc;
    } f1_t;

    typedef struct packed {
        word_t w;
        word_t g;
        word_t h;
        prod_t p;
        logic  skip;
    } f2_t;

    typedef struct packed {
        word_t w;
        word_t g;
        word_t h;
    } f3_t;

    typedef struct packed {
        word_t w;
        word_t g;
        word_t h;
        prod_t pd;
    } f4_t;

    logic [4:0] valid_reg;
    f1_t        f1_reg, f1_next;
    f2_t        f2_reg, f2_next;
    f3_t        f3_reg, f3_next;
    f4_t        f4_reg, f4_next;
    mid_item_t  f5_reg, f5_next;

    always_comb
    begin
        f1_next.w  = item.weight_in;
        f1_next.h  = item.history_in;
        f1_next.sc = item.scale_in;
        f1_next.g  = item.gradient_in;
        if (cfg.grad_ceil > cfg.grad_floor)
        begin
            if (item.gradient_in > cfg.grad_ceil)
                f1_next.g = cfg.grad_ceil;
            else if (item.gradient_in < cfg.grad_floor)
                f1_next.g = cfg.grad_floor;
        end
    end

    always_comb
    begin
        f2_next.w    = f1_reg.w;
        f2_next.g    = f1_reg.g;
        f2_next.h    = f1_reg.h;
        f2_next.p    = prod_t'(f1_reg.g) * prod_t'(f1_reg.sc);
        f2_next.skip = (f1_reg.sc == ONE_FX);
    end

    always_comb
    begin
        f3_next.w = f2_reg.w;
        f3_next.h = f2_reg.h;
        f3_next.g = f2_reg.skip ? f2_reg.g : fx_round(f2_reg.p);
    end

    always_comb
    begin
        f4_next.w  = f3_reg.w;
        f4_next.g  = f3_reg.g;
        f4_next.h  = f3_reg.h;
        f4_next.pd = prod_t'($signed({1'b0, cfg.decay_weight})) * prod_t'(f3_reg.w);
    end

    always_comb
    begin
        f5_next.mode = cfg.mode;
        f5_next.w    = f4_reg.w;
        f5_next.h    = f4_reg.h;
        f5_next.g    = (cfg.decay_weight != '0) ? add_sat(f4_reg.g, fx_round(f4_reg.pd))
                                                : f4_reg.g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[3:0], accept};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
            f5_reg <= f5_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_item  = f5_reg;

endmodule

@@ hw/rtl/owu_midq.sv @@
`timescale 1ns / 1ps

module owu_midq
    import owu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  mid_item_t    wdata,
    input  logic         pop,
    output logic         nonempty,
    output mid_item_t    rdata,
    output midq_status_t status
);

    mid_item_t                q_reg [MIDQ_DEPTH];
    logic [MIDQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [MIDQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [MIDQ_CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= wdata;
    end

    assign nonempty     = (cnt_reg != '0);
    assign rdata        = q_reg[rd_ptr_reg];
    assign status.count = cnt_reg;

endmodule

@@ hw/rtl/owu_back.sv @@
`timescale 1ns / 1ps

module owu_back
    import owu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  mid_item_t  in_item,
    output logic       in_pop,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    output bk_status_t status
);

    localparam int V_BITS     = WORD_BITS + FRAC_BITS;
    localparam int ROOT_BITS  = (V_BITS + 1) / 2;
    localparam int SREM_BITS  = V_BITS + 1;
    localparam int NUM_BITS   = PROD_BITS - 1;
    localparam int Q_BITS     = WORD_BITS - 1;
    localparam int OVF_STAGE  = ROOT_BITS + 1;
    localparam int LAST       = ROOT_BITS + Q_BITS + 2;
    localparam int NPL        = LAST + 1;
    localparam int OQ_DEPTH   = 2;
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        mode_t mode;
        word_t w;
        word_t h;
        prod_t p_mh;
        prod_t p_lg;
        prod_t p_gg;
        prod_t p_rh;
    } b1_t;

    typedef struct packed {
        mode_t mode;
        word_t w;
        word_t h;
        word_t mh;
        word_t lg;
        word_t sq;
        word_t rh;
        prod_t num;
    } b2_t;

    typedef struct packed {
        mode_t mode;
        word_t w;
        word_t h;
        word_t mh;
        word_t rh;
        prod_t num;
        word_t ha;
        word_t w0;
        word_t h2;
        prod_t p_rs;
    } b3_t;

    typedef struct packed {
        mode_t mode;
        word_t w;
        word_t mh;
        prod_t num;
        word_t w0;
        word_t hn;
        prod_t p_n;
    } b4_t;

    // The radicand carries two extra bits: history plus delta can pass the word maximum.
    typedef struct packed {
        mode_t                       mode;
        word_t                       w;
        prod_t                       num;
        word_t                       hn;
        word_t                       wf;
        word_t                       t;
        logic signed [WORD_BITS+1:0] rad;
    } b5_t;

    // Shared record of the square root and divider stages.
    typedef struct packed {
        mode_t                 mode;
        word_t                 w;
        word_t                 hn;
        word_t                 wf;
        word_t                 step;
        logic [NUM_BITS-1:0]   numabs;
        logic                  nneg;
        logic                  nzero;
        logic                  ovf;
        logic [SREM_BITS-1:0]  srem;
        logic [ROOT_BITS-1:0]  root;
        logic [Q_BITS-1:0]     q;
    } pl_t;

    logic [4:0]     b_valid_reg;
    logic [LAST:0]  pl_valid_reg;
    b1_t            b1_reg, b1_next;
    b2_t            b2_reg, b2_next;
    b3_t            b3_reg, b3_next;
    b4_t            b4_reg, b4_next;
    b5_t            b5_reg, b5_next;
    pl_t            pl_reg [NPL];
    pl_t            pl0_next;

    logic signed [MF_BITS:0]   mom_s;
    logic signed [MF_BITS:0]   rho_s;
    logic signed [MF_BITS:0]   one_minus_rho;
    logic signed [MF_BITS+1:0] one_plus_mom;
    logic                      mom_on;

    out_item_t                oq_reg [OQ_DEPTH];
    logic                     oq_wr_ptr_reg;
    logic                     oq_rd_ptr_reg;
    logic [OQ_CNT_BITS-1:0]   oq_cnt_reg, oq_cnt_next;
    logic                     adv;
    logic                     oq_push;
    logic                     oq_pop;
    out_item_t                oq_wdata;

    assign mom_s         = $signed({1'b0, cfg.momentum_factor});
    assign rho_s         = $signed({1'b0, cfg.rho_factor});
    assign one_minus_rho = (MF_BITS+1)'(ONE_FX) - rho_s;
    assign one_plus_mom  = (MF_BITS+2)'(ONE_FX) + (MF_BITS+2)'(mom_s);
    assign mom_on        = (cfg.momentum_factor != '0);

    // The whole back pipeline moves together; it holds on a full output queue with no pop.
    assign oq_pop = pop & ~empty;
    assign adv    = (oq_cnt_reg != OQ_CNT_BITS'(OQ_DEPTH)) | oq_pop;
    assign in_pop = adv & in_valid;

    always_comb
    begin
        b1_next.mode = in_item.mode;
        b1_next.w    = in_item.w;
        b1_next.h    = in_item.h;
        b1_next.p_mh = prod_t'(mom_s) * prod_t'(in_item.h);
        b1_next.p_lg = prod_t'($signed({1'b0, cfg.learn_rate})) * prod_t'(in_item.g);
        b1_next.p_gg = prod_t'(in_item.g) * prod_t'(in_item.g);
        b1_next.p_rh = prod_t'(rho_s) * prod_t'(in_item.h);
    end

    always_comb
    begin
        b2_next.mode = b1_reg.mode;
        b2_next.w    = b1_reg.w;
        b2_next.h    = b1_reg.h;
        b2_next.mh   = fx_round(b1_reg.p_mh);
        b2_next.lg   = fx_round(b1_reg.p_lg);
        b2_next.sq   = fx_round(b1_reg.p_gg);
        b2_next.rh   = fx_round(b1_reg.p_rh);
        b2_next.num  = b1_reg.p_lg;
    end

    always_comb
    begin
        b3_next.mode = b2_reg.mode;
        b3_next.w    = b2_reg.w;
        b3_next.h    = b2_reg.h;
        b3_next.mh   = b2_reg.mh;
        b3_next.rh   = b2_reg.rh;
        b3_next.num  = b2_reg.num;
        b3_next.ha   = (b2_reg.mode == MODE_NESTEROV) ? add_sat(b2_reg.mh, b2_reg.lg)
                                                      : sub_sat(b2_reg.mh, b2_reg.lg);
        b3_next.w0   = sub_sat(b2_reg.w, b2_reg.lg);
        b3_next.h2   = add_sat(b2_reg.h, b2_reg.sq);
        b3_next.p_rs = prod_t'(one_minus_rho) * prod_t'(b2_reg.sq);
    end

    always_comb
    begin
        b4_next.mode = b3_reg.mode;
        b4_next.w    = b3_reg.w;
        b4_next.mh   = b3_reg.mh;
        b4_next.num  = b3_reg.num;
        b4_next.w0   = b3_reg.w0;
        b4_next.p_n  = prod_t'(one_plus_mom) * prod_t'(b3_reg.ha);
        case (b3_reg.mode)
            MODE_SGD:      b4_next.hn = mom_on ? b3_reg.ha : b3_reg.h;
            MODE_NESTEROV: b4_next.hn = b3_reg.ha;
            MODE_ADAGRAD:  b4_next.hn = b3_reg.h2;
            MODE_RMSPROP:  b4_next.hn = add_sat(b3_reg.rh, fx_round(b3_reg.p_rs));
            default:       b4_next.hn = b3_reg.h;
        endcase
    end

    always_comb
    begin
        b5_next.mode = b4_reg.mode;
        b5_next.w    = b4_reg.w;
        b5_next.num  = b4_reg.num;
        b5_next.hn   = b4_reg.hn;
        b5_next.t    = sub_sat(fx_round(b4_reg.p_n), b4_reg.mh);
        b5_next.wf   = mom_on ? add_sat(b4_reg.w, b4_reg.hn) : b4_reg.w0;
        b5_next.rad  = {{2{b4_reg.hn[WORD_BITS-1]}}, b4_reg.hn}
                     + {3'b000, cfg.delta_term};
    end

    // Start of the root and divide chain: magnitude and sign of lr*g, radicand.
    always_comb
    begin
        pl0_next.mode   = b5_reg.mode;
        pl0_next.w      = b5_reg.w;
        pl0_next.hn     = b5_reg.hn;
        pl0_next.wf     = (b5_reg.mode == MODE_NESTEROV) ? sub_sat(b5_reg.w, b5_reg.t)
                                                         : b5_reg.wf;
        pl0_next.step   = '0;
        pl0_next.numabs = b5_reg.num[PROD_BITS-1] ? NUM_BITS'(-b5_reg.num)
                                                  : NUM_BITS'(b5_reg.num);
        pl0_next.nneg   = b5_reg.num[PROD_BITS-1];
        pl0_next.nzero  = (b5_reg.num == '0);
        pl0_next.ovf    = 1'b0;
        // A radicand that is not positive gives a root of zero.
        if (!b5_reg.rad[WORD_BITS+1] && (b5_reg.rad != '0))
            pl0_next.srem = SREM_BITS'({b5_reg.rad[WORD_BITS:0], {FRAC_BITS{1'b0}}});
        else
            pl0_next.srem = '0;
        pl0_next.root   = '0;
        pl0_next.q      = '0;
    end

    for (genvar j = 1; j < NPL; j++)
    begin : g_pl
        pl_t pl_next;

        if (j <= ROOT_BITS)
        begin : g_sqrt
            localparam int I = ROOT_BITS - j;
            logic [SREM_BITS-1:0] cand;

            always_comb
            begin
                pl_next = pl_reg[j-1];
                cand    = (SREM_BITS'(pl_reg[j-1].root) << (I + 1))
                        | (SREM_BITS'(1) << (2 * I));
                if (pl_reg[j-1].srem >= cand)
                begin
                    pl_next.srem    = pl_reg[j-1].srem - cand;
                    pl_next.root[I] = 1'b1;
                end
            end
        end
        else if (j == OVF_STAGE)
        begin : g_ovf
            // The quotient reaches the word limit when |num| >= root * 2^Q_BITS.
            always_comb
            begin
                pl_next     = pl_reg[j-1];
                pl_next.ovf = (NUM_BITS'(pl_reg[j-1].numabs >> Q_BITS)
                               >= NUM_BITS'(pl_reg[j-1].root));
            end
        end
        else if (j < LAST)
        begin : g_div
            localparam int K = LAST - 1 - j;
            logic [NUM_BITS-1:0] dsh;

            always_comb
            begin
                pl_next = pl_reg[j-1];
                dsh     = NUM_BITS'(pl_reg[j-1].root) << K;
                if (pl_reg[j-1].numabs >= dsh)
                begin
                    pl_next.numabs = pl_reg[j-1].numabs - dsh;
                    pl_next.q[K]   = 1'b1;
                end
            end
        end
        else
        begin : g_step
            always_comb
            begin
                pl_next = pl_reg[j-1];
                if (pl_reg[j-1].nzero)
                    pl_next.step = '0;
                else if (pl_reg[j-1].ovf)
                    pl_next.step = pl_reg[j-1].nneg ? WORD_MIN : WORD_MAX;
                else if (pl_reg[j-1].nneg)
                    pl_next.step = -word_t'({1'b0, pl_reg[j-1].q});
                else
                    pl_next.step = word_t'({1'b0, pl_reg[j-1].q});
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                pl_reg[j] <= pl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg    <= b1_next;
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            b4_reg    <= b4_next;
            b5_reg    <= b5_next;
            pl_reg[0] <= pl0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= '0;
            pl_valid_reg <= '0;
        end
        else if (adv)
        begin
            b_valid_reg  <= {b_valid_reg[3:0], in_valid};
            pl_valid_reg <= {pl_valid_reg[LAST-1:0], b_valid_reg[4]};
        end
    end

    // Output queue.
    always_comb
    begin
        oq_wdata.history_out = pl_reg[LAST].hn;
        if ((pl_reg[LAST].mode == MODE_ADAGRAD) || (pl_reg[LAST].mode == MODE_RMSPROP))
            oq_wdata.weight_out = sub_sat(pl_reg[LAST].w, pl_reg[LAST].step);
        else
            oq_wdata.weight_out = pl_reg[LAST].wf;
    end

    assign oq_push = adv & pl_valid_reg[LAST];

    always_comb
    begin
        case ({oq_push, oq_pop})
            2'b10:   oq_cnt_next = oq_cnt_reg + 1'b1;
            2'b01:   oq_cnt_next = oq_cnt_reg - 1'b1;
            default: oq_cnt_next = oq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= 1'b0;
            oq_rd_ptr_reg <= 1'b0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_ptr_reg <= ~oq_wr_ptr_reg;
            if (oq_pop)
                oq_rd_ptr_reg <= ~oq_rd_ptr_reg;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_reg[oq_wr_ptr_reg] <= oq_wdata;
    end

    assign empty          = (oq_cnt_reg == '0);
    assign result         = oq_reg[oq_rd_ptr_reg];
    assign status.adv     = adv;
    assign status.oq_full = (oq_cnt_reg == OQ_CNT_BITS'(OQ_DEPTH));

endmodule

@@ hw/rtl/optimizer_weight_update_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                           Transfer at rising edge
// config    cfg_we, cfg_index, cfg_data     cfg_we high
// input     push, full, item                push high and full low
// result    empty, pop, result              pop high and empty low
//
// One item is taken per cycle and one result leaves per cycle when pop keeps up.
// Items pass five front stages, the queue, five update stages, a 24-stage square
// root and a 31-stage divider, then the output queue.
// Reset clears the configuration to its defaults and empties every queue.
// A full output queue stalls the back pipeline unless a result is popped; the front
// stalls on a full, unpopped mid queue, and full is raised to the producer then.

`include "optimizer_weight_update_unit_macros.svh"

module optimizer_weight_update_unit
    import owu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     push,
    output logic                     full,
    input  in_item_t                 item,
    output logic                     empty,
    input  logic                     pop,
    output out_item_t                result
);

    cfg_t         cfg_reg;
    logic         front_adv;
    logic         front_valid;
    mid_item_t    front_item;
    logic         mid_nonempty;
    logic         mid_pop;
    mid_item_t    mid_item;
    midq_status_t mid_stat;
    bk_status_t   bk_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= MODE_SGD;
            cfg_reg.learn_rate      <= RATE_BITS'(655);
            cfg_reg.decay_weight    <= '0;
            cfg_reg.momentum_factor <= '0;
            cfg_reg.rho_factor      <= MF_BITS'(58982);
            cfg_reg.delta_term      <= RATE_BITS'(1);
            cfg_reg.grad_floor      <= '0;
            cfg_reg.grad_ceil       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:       cfg_reg.mode            <= mode_t'(cfg_data[1:0]);
                CFG_LEARN_RATE: cfg_reg.learn_rate      <= cfg_data[RATE_BITS-1:0];
                CFG_DECAY:      cfg_reg.decay_weight    <= cfg_data[RATE_BITS-1:0];
                CFG_MOMENTUM:   cfg_reg.momentum_factor <= cfg_data[MF_BITS-1:0];
                CFG_RHO:        cfg_reg.rho_factor      <= cfg_data[MF_BITS-1:0];
                CFG_DELTA:      cfg_reg.delta_term      <= cfg_data[RATE_BITS-1:0];
                CFG_GRAD_FLOOR: cfg_reg.grad_floor      <= word_t'(cfg_data);
                CFG_GRAD_CEIL:  cfg_reg.grad_ceil       <= word_t'(cfg_data);
                default:        ;
            endcase
        end
    end

    assign front_adv = (mid_stat.count != MIDQ_CNT_BITS'(MIDQ_DEPTH)) | mid_pop;
    assign full      = ~front_adv;

    owu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (push & front_adv),
        .item      (item),
        .adv       (front_adv),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    owu_midq u_midq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_adv & front_valid),
        .wdata    (front_item),
        .pop      (mid_pop),
        .nonempty (mid_nonempty),
        .rdata    (mid_item),
        .status   (mid_stat)
    );

    owu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (mid_nonempty),
        .in_item  (mid_item),
        .in_pop   (mid_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .status   (bk_stat)
    );

    `OWU_ASSERT_IMPLY(a_midq_bound, 1'b1, mid_stat.count <= MIDQ_CNT_BITS'(MIDQ_DEPTH), "midq overflow")
    `OWU_ASSERT_NEXT(a_stall_keeps_result, !bk_stat.adv, !empty, "result lost during back stall")
    `OWU_ASSERT_IMPLY(a_stall_only_when_full, !bk_stat.adv, bk_stat.oq_full && !pop, "stall without cause")

endmodule

@@ tb/sv/optimizer_weight_update_unit_tb.sv @@
`timescale 1ns / 1ps

module optimizer_weight_update_unit_tb;
    import owu_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;

    // Predictor settings, kept wide so the products stay exact.
    typedef struct {
        mode_t   mode;
        longint  rate;
        longint  decay;
        longint  mom;
        longint  rho;
        longint  delta;
        longint  clip_lo;
        longint  clip_hi;
    } opt_settings_t;

    class update_scoreboard;
        opt_settings_t s;
        out_item_t     pending[$];
        int            mismatches;
        int            checked;

        function new();
            s.mode = MODE_SGD;
            s.rate = 655;
            s.decay = 0;
            s.mom = 0;
            s.rho = 58982;
            s.delta = 1;
            s.clip_lo = 0;
            s.clip_hi = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint clamp(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function longint qmul(longint a, longint b);
            longint p;
            p = a * b + 32768;
            return clamp(p >>> 16);
        endfunction

        function longint int_root(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > v)
                b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - r - b;
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint scaled_step(longint g, longint h);
            longint num;
            longint rad;
            longint root;
            num = s.rate * g;
            rad = h + s.delta;
            root = 0;
            if (rad > 0)
                root = int_root(rad <<< 16);
            if (root == 0)
            begin
                if (num > 0)
                    return 64'sd2147483647;
                if (num < 0)
                    return -64'sd2147483648;
                return 0;
            end
            // SystemVerilog integer division truncates toward zero.
            return clamp(num / root);
        endfunction

        function void note_input(in_item_t it);
            longint w;
            longint g;
            longint h;
            longint sc;
            longint wn;
            longint hn;
            longint t;
            longint sq;
            out_item_t r;
            w = longint'(it.weight_in);
            g = longint'(it.gradient_in);
            h = longint'(it.history_in);
            sc = longint'(it.scale_in);
            wn = w;
            hn = h;
            if (s.clip_hi > s.clip_lo)
            begin
                if (g > s.clip_hi)
                    g = s.clip_hi;
                else if (g < s.clip_lo)
                    g = s.clip_lo;
            end
            if (sc != 65536)
                g = qmul(g, sc);
            if (s.decay > 0)
                g = clamp(g + qmul(s.decay, w));
            case (s.mode)
                MODE_SGD:
                begin
                    if (s.mom > 0)
                    begin
                        hn = clamp(qmul(s.mom, h) - qmul(s.rate, g));
                        wn = clamp(w + hn);
                    end
                    else
                        wn = clamp(w - qmul(s.rate, g));
                end
                MODE_NESTEROV:
                begin
                    hn = clamp(qmul(s.mom, h) + qmul(s.rate, g));
                    t = clamp(qmul(hn, 65536 + s.mom) - qmul(h, s.mom));
                    wn = clamp(w - t);
                end
                default:
                begin
                    sq = qmul(g, g);
                    if (s.mode == MODE_ADAGRAD)
                        hn = clamp(h + sq);
                    else
                        hn = clamp(qmul(s.rho, h) + qmul(65536 - s.rho, sq));
                    wn = clamp(w - scaled_step(g, hn));
                end
            endcase
            r.weight_out = word_t'(wn);
            r.history_out = word_t'(hn);
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %h", got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.weight_out !== exp_r.weight_out
                || got.history_out !== exp_r.history_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d: weight exp %0d got %0d, history exp %0d got %0d",
                             checked, exp_r.weight_out, got.weight_out,
                             exp_r.history_out, got.history_out);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     push;
    logic                     full;
    in_item_t                 item;
    logic                     empty;
    logic                     pop;
    out_item_t                result;

    update_scoreboard board;
    int  push_idle_pct;
    int  pop_idle_pct;
    int  quiet_cycles;
    bit  timed_out;

    optimizer_weight_update_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: check on every transfer, choose the next pop at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                board.check_result(result);
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input longint val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[31:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:       board.s.mode = mode_t'(val[1:0]);
            CFG_LEARN_RATE: board.s.rate = longint'(val[30:0]);
            CFG_DECAY:      board.s.decay = longint'(val[30:0]);
            CFG_MOMENTUM:   board.s.mom = longint'(val[16:0]);
            CFG_RHO:        board.s.rho = longint'(val[16:0]);
            CFG_DELTA:      board.s.delta = longint'(val[30:0]);
            CFG_GRAD_FLOOR: board.s.clip_lo = longint'(signed'(val[31:0]));
            default:        board.s.clip_hi = longint'(signed'(val[31:0]));
        endcase
    endtask

    // Send one item; push stays high across back-to-back items.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_input(it);
    endtask

    task automatic go_idle();
        push <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($urandom_range(65536 * 4)) - word_t'(65536 * 2);
            3: return word_t'($urandom_range(65536 * 64)) - word_t'(65536 * 32);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.weight_in = rand_word();
        it.gradient_in = rand_word();
        it.history_in = ($urandom_range(3) == 0) ? rand_word()
                        : word_t'($urandom_range(65536 * 16));
        case ($urandom_range(3))
            0: it.scale_in = ONE_FX;
            1: it.scale_in = rand_word();
            default: it.scale_in = word_t'($urandom_range(65536 * 2));
        endcase
        return it;
    endfunction

    function automatic in_item_t make_item(word_t w, word_t g, word_t h, word_t sc);
        in_item_t it;
        it.weight_in = w;
        it.gradient_in = g;
        it.history_in = h;
        it.scale_in = sc;
        return it;
    endfunction

    task automatic random_settings(input int pick);
        write_reg(CFG_MODE, pick % 4);
        case ($urandom_range(3))
            0: write_reg(CFG_LEARN_RATE, 0);
            1: write_reg(CFG_LEARN_RATE, 32'h7FFFFFFF);
            default: write_reg(CFG_LEARN_RATE, $urandom_range(65536 * 2));
        endcase
        write_reg(CFG_DECAY, ($urandom_range(2) == 0) ? 0
                  : (($urandom_range(4) == 0) ? 32'h7FFFFFFF : $urandom_range(6554)));
        write_reg(CFG_MOMENTUM, ($urandom_range(3) == 0) ? 0
                  : (($urandom_range(3) == 0) ? 65536 : $urandom_range(65536)));
        write_reg(CFG_RHO, ($urandom_range(4) == 0) ? 131071 : $urandom_range(65536));
        write_reg(CFG_DELTA, ($urandom_range(3) == 0) ? 0
                  : (($urandom_range(5) == 0) ? 32'h7FFFFFFF : $urandom_range(100)));
        if ($urandom_range(1))
        begin
            write_reg(CFG_GRAD_FLOOR, -longint'($urandom_range(65536 * 4)));
            write_reg(CFG_GRAD_CEIL, $urandom_range(65536 * 4));
        end
        else
        begin
            write_reg(CFG_GRAD_FLOOR, $urandom);
            write_reg(CFG_GRAD_CEIL, $urandom);
        end
    endtask

    initial
    begin
        board = new();
        timed_out = 1'b0;
        push_idle_pct = 32;
        pop_idle_pct = 69;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        item = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: reset settings, then extremes in every mode.
        send_item(make_item(ONE_FX, ONE_FX, 0, ONE_FX));
        send_item(make_item(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
        send_item(make_item(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
        go_idle();
        write_reg(CFG_GRAD_FLOOR, -65536);
        write_reg(CFG_GRAD_CEIL, 65536);
        write_reg(CFG_DECAY, 655);
        write_reg(CFG_MOMENTUM, 58982);
        write_reg(CFG_LEARN_RATE, 32'h7FFFFFFF);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(CFG_MODE, m);
            send_item(make_item(WORD_MAX, WORD_MAX, WORD_MAX, ONE_FX));
            send_item(make_item(WORD_MIN, WORD_MIN, WORD_MIN, 0));
            // Negative history drives the radicand below zero: zero root.
            send_item(make_item(0, 65536 * 3, -65536 * 5, ONE_FX));
            send_item(make_item(0, 0, -65536 * 5, ONE_FX));
            go_idle();
        end
        // Rho above one and zero delta.
        write_reg(CFG_RHO, 131071);
        write_reg(CFG_DELTA, 0);
        write_reg(CFG_LEARN_RATE, 655);
        send_item(make_item(65536, 65536 * 2, 65536, ONE_FX));
        send_item(make_item(-65536, 0, 0, ONE_FX));
        go_idle();

        for (int ph = 0; ph < 3; ph++)
        begin
            push_idle_pct = (ph == 0) ? 32 : ((ph == 1) ? 69 : 0);
            pop_idle_pct = (ph == 0) ? 69 : ((ph == 1) ? 32 : 0);
            for (int blk = 0; blk < 8; blk++)
            begin
                go_idle();
                random_settings(blk + ph);
                repeat (60)
                    send_item(rand_item());
            end
        end
        go_idle();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/owu_pkg.sv
hw/rtl/owu_front.sv
hw/rtl/owu_midq.sv
hw/rtl/owu_back.sv
hw/rtl/optimizer_weight_update_unit.sv
tb/sv/optimizer_weight_update_unit_tb.sv
